[hw/rtl/sfr_pkg.sv]
package sfr_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int FRAME_LIMIT = (STORE_DEPTH < 16) ? STORE_DEPTH : 16;
  localparam int CNT_W       = $clog2(FRAME_LIMIT + 1);
  localparam int ADDR_W      = $clog2(FRAME_LIMIT);
  localparam int CMP_W       = ((CNT_W > 5) ? CNT_W : 5) + 1;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int IDX_W       = 4;
  localparam int CFG_IDX_W   = 2;

  localparam int HEADER_BYTES = 2;
  localparam int LEN_POS      = 3;
  localparam int FRAME_EXTRA  = 3;
  localparam int MIN_FRAME    = 4;
  localparam int MAX_LEN      = FRAME_LIMIT - FRAME_EXTRA;

  localparam logic [BYTE_W-1:0] HEADER_RST  = 8'h55;
  localparam logic [LEN_W-1:0]  MIN_LEN_RST = 4'd3;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST = 4'd7;
  localparam logic [LEN_W-1:0]  FLEN_RST    = 4'd2;
  localparam logic [LEN_W-1:0]  FLEN_ABORT  = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER  = 2'd0,
    REG_MIN_LEN = 2'd1,
    REG_MAX_LEN = 2'd2
  } cfg_reg_t;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic byte_acc;
    logic take_acc;
    logic emit_step;
  } sfr_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic out_free;
    logic emit_last;
  } sfr_status_t;

endpackage

[hw/rtl/servo_frame_receiver.sv]
// Serial servo frame receiver. Each input beat is either a received byte or a
// take request. A received byte is absorbed by the header/length tracker and a
// register store of the frame bytes in the datapath. When a frame of L+3 bytes
// completes and no earlier frame is pending, it is marked pending and read out
// of the store one beat per cycle while the output is not stalled, headers
// first; input is stalled during that read-out. A take request is answered
// with one beat and clears the pending mark. Any item also waits while the
// output register holds a beat that has not been taken.
module servo_frame_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [sfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfr_pkg::BYTE_W-1:0]    out_frame_byte,
  output logic [sfr_pkg::IDX_W-1:0]     out_byte_index,
  output logic                          out_last_byte,
  output logic                          out_is_answer,
  output logic                          out_had_frame
);

  sfr_pkg::sfr_cmd_t    cmd;
  sfr_pkg::sfr_status_t status;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sfr_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_rx_byte     (in_rx_byte),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte),
    .out_is_answer  (out_is_answer),
    .out_had_frame  (out_had_frame)
  );

endmodule

[hw/rtl/sfr_ctrl.sv]
module sfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_stall,
  input  sfr_pkg::sfr_status_t status,
  output sfr_pkg::sfr_cmd_t    cmd
);

  sfr_pkg::state_t state_r;
  sfr_pkg::state_t state_nxt;
  logic            accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfr_pkg::ST_IDLE: begin
        if (accept && (in_kind == sfr_pkg::KIND_BYTE) && status.frame_done) begin
          state_nxt = sfr_pkg::ST_EMIT;
        end
      end
      sfr_pkg::ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_nxt = sfr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.byte_acc  = 1'b0;
    cmd.take_acc  = 1'b0;
    cmd.emit_step = 1'b0;
    unique case (state_r)
      sfr_pkg::ST_IDLE: begin
        in_stall     = !status.out_free;
        cmd.byte_acc = in_valid && status.out_free && (in_kind == sfr_pkg::KIND_BYTE);
        cmd.take_acc = in_valid && status.out_free && (in_kind == sfr_pkg::KIND_TAKE);
      end
      sfr_pkg::ST_EMIT: begin
        cmd.emit_step = status.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

[hw/rtl/sfr_datapath.sv]
module sfr_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]           cfg_wdata,
  input  logic [sfr_pkg::BYTE_W-1:0]           in_rx_byte,
  input  sfr_pkg::sfr_cmd_t                    cmd,
  output sfr_pkg::sfr_status_t                 status,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sfr_pkg::BYTE_W-1:0]           out_frame_byte,
  output logic [sfr_pkg::IDX_W-1:0]            out_byte_index,
  output logic                                 out_last_byte,
  output logic                                 out_is_answer,
  output logic                                 out_had_frame
);

  logic [sfr_pkg::BYTE_W-1:0] header_r;
  logic [sfr_pkg::LEN_W-1:0]  min_len_r;
  logic [sfr_pkg::LEN_W-1:0]  max_len_r;

  logic                       in_frame_r, in_frame_nxt;
  logic                       header_seen_r, header_seen_nxt;
  logic [sfr_pkg::LEN_W-1:0]  frame_length_r, frame_length_nxt;
  logic [sfr_pkg::CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic                       pending_r;

  logic [sfr_pkg::BYTE_W-1:0] store_r [sfr_pkg::FRAME_LIMIT];
  logic                       store_we;
  logic [sfr_pkg::ADDR_W-1:0] store_addr;

  logic [sfr_pkg::CNT_W-1:0]  emit_idx_r;
  logic [sfr_pkg::CNT_W-1:0]  run_len_r;

  logic                       out_valid_r;
  logic [sfr_pkg::BYTE_W-1:0] out_frame_byte_r;
  logic [sfr_pkg::IDX_W-1:0]  out_byte_index_r;
  logic                       out_last_byte_r;
  logic                       out_is_answer_r;
  logic                       out_had_frame_r;

  logic                       in_frame_a;
  logic [sfr_pkg::CNT_W-1:0]  cnt_a;
  logic [sfr_pkg::CNT_W-1:0]  cnt_inc;
  logic                       len_ok;
  logic                       len_bad;
  logic                       byte_done;
  logic                       out_free;
  logic                       emit_last;
  logic [sfr_pkg::BYTE_W-1:0] emit_byte;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit_last = ((emit_idx_r + sfr_pkg::CNT_W'(1)) == run_len_r);
  assign emit_byte = (emit_idx_r < sfr_pkg::CNT_W'(sfr_pkg::HEADER_BYTES)) ?
                     header_r : store_r[emit_idx_r[sfr_pkg::ADDR_W-1:0]];

  assign len_bad = (in_rx_byte < {4'd0, min_len_r}) ||
                   (in_rx_byte > {4'd0, max_len_r}) ||
                   (in_rx_byte == '0) ||
                   (in_rx_byte > sfr_pkg::BYTE_W'(sfr_pkg::MAX_LEN));

  always_comb begin
    header_seen_nxt  = header_seen_r;
    frame_length_nxt = frame_length_r;
    in_frame_a       = in_frame_r;
    cnt_a            = byte_count_r;
    cnt_inc          = '0;
    len_ok           = 1'b1;
    byte_done        = 1'b0;
    store_we         = 1'b0;
    if (!in_frame_r) begin
      if (in_rx_byte == header_r) begin
        if (header_seen_r) begin
          header_seen_nxt = 1'b0;
          in_frame_a      = 1'b1;
          cnt_a           = sfr_pkg::CNT_W'(1);
        end else begin
          header_seen_nxt = 1'b1;
        end
      end else begin
        header_seen_nxt = 1'b0;
        cnt_a           = '0;
      end
    end
    in_frame_nxt   = in_frame_a;
    byte_count_nxt = cnt_a;
    if (in_frame_a) begin
      store_we = 1'b1;
      if (cnt_a == sfr_pkg::CNT_W'(sfr_pkg::LEN_POS)) begin
        if (len_bad) begin
          frame_length_nxt = sfr_pkg::FLEN_ABORT;
          in_frame_nxt     = 1'b0;
          byte_count_nxt   = '0;
          len_ok           = 1'b0;
        end else begin
          frame_length_nxt = in_rx_byte[sfr_pkg::LEN_W-1:0];
        end
      end
      if (len_ok) begin
        cnt_inc        = cnt_a + sfr_pkg::CNT_W'(1);
        byte_count_nxt = cnt_inc;
        if ((cnt_inc >= sfr_pkg::CNT_W'(sfr_pkg::MIN_FRAME)) &&
            (sfr_pkg::CMP_W'(cnt_inc) ==
             sfr_pkg::CMP_W'(frame_length_nxt) + sfr_pkg::CMP_W'(sfr_pkg::FRAME_EXTRA))) begin
          byte_done      = 1'b1;
          in_frame_nxt   = 1'b0;
          byte_count_nxt = '0;
        end
      end
    end
  end

  assign store_addr = cnt_a[sfr_pkg::ADDR_W-1:0];

  assign status.frame_done = byte_done && !pending_r;
  assign status.out_free   = out_free;
  assign status.emit_last  = emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= sfr_pkg::HEADER_RST;
      min_len_r <= sfr_pkg::MIN_LEN_RST;
      max_len_r <= sfr_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfr_pkg::REG_HEADER:  header_r  <= cfg_wdata;
        sfr_pkg::REG_MIN_LEN: min_len_r <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_MAX_LEN: max_len_r <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r     <= 1'b0;
      header_seen_r  <= 1'b0;
      frame_length_r <= sfr_pkg::FLEN_RST;
      byte_count_r   <= '0;
      pending_r      <= 1'b0;
    end else if (cmd.byte_acc) begin
      in_frame_r     <= in_frame_nxt;
      header_seen_r  <= header_seen_nxt;
      frame_length_r <= frame_length_nxt;
      byte_count_r   <= byte_count_nxt;
      if (byte_done) begin
        pending_r <= 1'b1;
      end
    end else if (cmd.take_acc) begin
      pending_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_acc && store_we) begin
      store_r[store_addr] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
      run_len_r  <= '0;
    end else if (cmd.byte_acc && byte_done && !pending_r) begin
      emit_idx_r <= '0;
      run_len_r  <= cnt_inc;
    end else if (cmd.emit_step) begin
      emit_idx_r <= emit_idx_r + sfr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.take_acc || cmd.emit_step) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_acc) begin
      out_frame_byte_r <= '0;
      out_byte_index_r <= '0;
      out_last_byte_r  <= 1'b0;
      out_is_answer_r  <= 1'b1;
      out_had_frame_r  <= pending_r;
    end else if (cmd.emit_step) begin
      out_frame_byte_r <= emit_byte;
      out_byte_index_r <= emit_idx_r[sfr_pkg::IDX_W-1:0];
      out_last_byte_r  <= emit_last;
      out_is_answer_r  <= 1'b0;
      out_had_frame_r  <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_frame_byte_r;
  assign out_byte_index = out_byte_index_r;
  assign out_last_byte  = out_last_byte_r;
  assign out_is_answer  = out_is_answer_r;
  assign out_had_frame  = out_had_frame_r;

endmodule
